// File: src/c8ie_pkg.sv
// ----------------------------------------------------------------------------
// c8ie_pkg
// Opcode codes, reset constants and the execute result type shared by the
// instruction execute core and its datapath.
// ----------------------------------------------------------------------------
package c8ie_pkg;

	localparam int ADDR_W = 12;
	localparam int REG_W  = 8;
	localparam int RIDX_W = 4;

	localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;
	localparam logic [RIDX_W-1:0] REG_V0   = 4'h0;
	localparam logic [RIDX_W-1:0] REG_VF   = 4'hF;

	// top-level opcode nibble
	localparam logic [3:0] OP_JP      = 4'h1;
	localparam logic [3:0] OP_SE_IMM  = 4'h3;
	localparam logic [3:0] OP_SNE_IMM = 4'h4;
	localparam logic [3:0] OP_SE_REG  = 4'h5;
	localparam logic [3:0] OP_LD_IMM  = 4'h6;
	localparam logic [3:0] OP_ADD_IMM = 4'h7;
	localparam logic [3:0] OP_ALU     = 4'h8;
	localparam logic [3:0] OP_SNE_REG = 4'h9;
	localparam logic [3:0] OP_LD_I    = 4'hA;
	localparam logic [3:0] OP_JP_V0   = 4'hB;

	// 8XY sub-op nibble
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_RSB = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	typedef struct packed {
		logic [ADDR_W-1:0] next_pc;
		logic [ADDR_W-1:0] index_value;
		logic [RIDX_W-1:0] dest_reg;
		logic [REG_W-1:0]  dest_value;
		logic              dest_written;
		logic              flag_value;
		logic              flag_written;
		logic              skipped;
		logic              unknown_opcode;
	} exec_t;

endpackage

// File: src/c8ie_ram.sv
// ----------------------------------------------------------------------------
// c8ie_ram
// Generic RAM: one write port, two read ports, registered read-first data.
// ----------------------------------------------------------------------------
module c8ie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// File: src/c8ie_exec.sv
// ----------------------------------------------------------------------------
// c8ie_exec
// Combinational decode and execute of one instruction word against the
// operand values, pc and index register.
// ----------------------------------------------------------------------------
module c8ie_exec
	import c8ie_pkg::*;
(
	input  logic [15:0]       word,
	input  logic [REG_W-1:0]  vx,
	input  logic [REG_W-1:0]  vy,
	input  logic [REG_W-1:0]  v0,
	input  logic [ADDR_W-1:0] pc,
	input  logic [ADDR_W-1:0] index_cur,
	output exec_t             res
);

	logic [3:0]        op;
	logic [3:0]        sub;
	logic [RIDX_W-1:0] x;
	logic [REG_W-1:0]  nn;
	logic [ADDR_W-1:0] nnn;
	logic [REG_W:0]    sum;
	logic [REG_W-1:0]  dv;
	logic              dw;
	logic              fw;
	logic              fv;
	logic              skip;
	logic              unk;
	logic              jump;
	logic [ADDR_W-1:0] jump_pc;
	logic [ADDR_W-1:0] idx;

	assign op  = word[15:12];
	assign x   = word[11:8];
	assign sub = word[3:0];
	assign nn  = word[7:0];
	assign nnn = word[11:0];
	assign sum = {1'b0, vx} + {1'b0, vy};

	always_comb begin
		dw      = 1'b0;
		dv      = '0;
		fw      = 1'b0;
		fv      = 1'b0;
		skip    = 1'b0;
		unk     = 1'b0;
		jump    = 1'b0;
		jump_pc = nnn;
		idx     = index_cur;
		unique case (op)
			OP_JP:      jump = 1'b1;
			OP_SE_IMM:  skip = (vx == nn);
			OP_SNE_IMM: skip = (vx != nn);
			OP_SE_REG:  skip = (vx == vy);
			OP_SNE_REG: skip = (vx != vy);
			OP_LD_IMM: begin
				dw = 1'b1;
				dv = nn;
			end
			OP_ADD_IMM: begin
				dw = 1'b1;
				dv = vx + nn;
			end
			OP_ALU: begin
				unique case (sub)
					ALU_MOV: begin dw = 1'b1; dv = vy;      end
					ALU_OR:  begin dw = 1'b1; dv = vx | vy; end
					ALU_AND: begin dw = 1'b1; dv = vx & vy; end
					ALU_XOR: begin dw = 1'b1; dv = vx ^ vy; end
					ALU_ADD: begin
						dw = 1'b1; fw = 1'b1;
						dv = sum[REG_W-1:0];
						fv = sum[REG_W];
					end
					ALU_SUB: begin
						dw = 1'b1; fw = 1'b1;
						dv = vx - vy;
						fv = (vx >= vy);
					end
					ALU_SHR: begin
						dw = 1'b1; fw = 1'b1;
						dv = {1'b0, vx[REG_W-1:1]};
						fv = vx[0];
					end
					ALU_RSB: begin
						dw = 1'b1; fw = 1'b1;
						dv = vy - vx;
						fv = (vy >= vx);
					end
					ALU_SHL: begin
						dw = 1'b1; fw = 1'b1;
						dv = {vx[REG_W-2:0], 1'b0};
						fv = vx[REG_W-1];
					end
					default: ; // unknown sub-op: pc advance only
				endcase
			end
			OP_LD_I: idx = nnn;
			OP_JP_V0: begin
				jump    = 1'b1;
				jump_pc = nnn + {{(ADDR_W-REG_W){1'b0}}, v0};
			end
			default: unk = 1'b1;
		endcase
	end

	always_comb begin
		res = '0;
		if (unk) begin
			res.next_pc = pc;
		end else if (jump) begin
			res.next_pc = jump_pc;
		end else if (skip) begin
			res.next_pc = pc + ADDR_W'(4);
		end else begin
			res.next_pc = pc + ADDR_W'(2);
		end
		res.index_value    = idx;
		res.dest_reg       = dw ? x : '0;
		res.dest_value     = dw ? dv : '0;
		res.dest_written   = dw;
		res.flag_value     = fw & fv;
		res.flag_written   = fw;
		res.skipped        = skip;
		res.unknown_opcode = unk;
	end

endmodule

// File: src/chip8_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_execute_core
// Executes one 16-bit interpreter instruction per transaction and reports
// the resulting pc, index register and register/flag writes.
//
// Usage:
//   Input channel:  instruction_word with in_valid / in_stall. One word is
//     taken per cycle while in_stall is low.
//   Output channel: one result transaction per instruction on out_valid /
//     out_stall, in instruction order.
//   Pipeline: input register, then output register. Throughput: one
//     instruction per cycle when not stalled, set by the single execute
//     stage that reads the register file and updates the state.
//   Stall: while out_stall holds a result, the instruction waiting in the
//     input register stays there and in_stall rises; no state changes.
//   Reset: pc = 0x200, index = 0, all registers read as zero (per-entry
//     valid bits), both channels empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_core
	import c8ie_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [15:0]       instruction_word,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ADDR_W-1:0] next_pc,
	output logic [ADDR_W-1:0] index_value,
	output logic [RIDX_W-1:0] dest_reg,
	output logic [REG_W-1:0]  dest_value,
	output logic              dest_written,
	output logic              flag_value,
	output logic              flag_written,
	output logic              skipped,
	output logic              unknown_opcode
);

	localparam int NREGS = 1 << RIDX_W;

	// input stage
	logic              valid_s1;
	logic [15:0]       word_s1;
	logic              fwd_x_s1;
	logic              fwd_y_s1;
	logic [REG_W-1:0]  fwd_data_s1;
	logic              vld_x_s1;
	logic              vld_y_s1;

	// architectural state; V0 and VF also live in flops for fixed-port reads
	logic [ADDR_W-1:0] pc_q;
	logic [ADDR_W-1:0] index_q;
	logic [REG_W-1:0]  v0_q;
	logic [REG_W-1:0]  vf_q;
	logic [NREGS-1:0]  reg_vld_q;

	logic              accept_in;
	logic              advance;
	logic [RIDX_W-1:0] in_x;
	logic [RIDX_W-1:0] in_y;
	logic [RIDX_W-1:0] x_s1;
	logic [RIDX_W-1:0] y_s1;
	logic [REG_W-1:0]  ram_x;
	logic [REG_W-1:0]  ram_y;
	logic [REG_W-1:0]  vx;
	logic [REG_W-1:0]  vy;
	logic              wr_en;
	exec_t             res;

	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	assign in_x = instruction_word[11:8];
	assign in_y = instruction_word[7:4];
	assign x_s1 = word_s1[11:8];
	assign y_s1 = word_s1[7:4];

	assign wr_en = advance && res.dest_written;

	// register file: read at accept, written when an instruction retires
	c8ie_ram #(
		.WIDTH (REG_W),
		.DEPTH (NREGS)
	) u_regfile (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (x_s1),
		.wr_data   (res.dest_value),
		.rd_en     (accept_in),
		.rd_addr_a (in_x),
		.rd_addr_b (in_y),
		.rd_data_a (ram_x),
		.rd_data_b (ram_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// the retiring instruction writes at the same edge the next word reads,
	// so catch that write for forwarding
	always_ff @(posedge clk) begin
		if (accept_in) begin
			word_s1     <= instruction_word;
			fwd_x_s1    <= wr_en && (x_s1 == in_x);
			fwd_y_s1    <= wr_en && (x_s1 == in_y);
			fwd_data_s1 <= res.dest_value;
			vld_x_s1    <= reg_vld_q[in_x];
			vld_y_s1    <= reg_vld_q[in_y];
		end
	end

	// operand select: fixed flops for V0/VF, else forwarded or RAM data;
	// an entry never written reads as zero
	always_comb begin
		if (x_s1 == REG_VF) begin
			vx = vf_q;
		end else if (x_s1 == REG_V0) begin
			vx = v0_q;
		end else if (fwd_x_s1) begin
			vx = fwd_data_s1;
		end else if (vld_x_s1) begin
			vx = ram_x;
		end else begin
			vx = '0;
		end
		if (y_s1 == REG_VF) begin
			vy = vf_q;
		end else if (y_s1 == REG_V0) begin
			vy = v0_q;
		end else if (fwd_y_s1) begin
			vy = fwd_data_s1;
		end else if (vld_y_s1) begin
			vy = ram_y;
		end else begin
			vy = '0;
		end
	end

	c8ie_exec u_exec (
		.word      (word_s1),
		.vx        (vx),
		.vy        (vy),
		.v0        (v0_q),
		.pc        (pc_q),
		.index_cur (index_q),
		.res       (res)
	);

	// state update on retire; a dest write to VF takes priority over the flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_RESET;
			index_q   <= '0;
			v0_q      <= '0;
			vf_q      <= '0;
			reg_vld_q <= '0;
		end else if (advance) begin
			pc_q    <= res.next_pc;
			index_q <= res.index_value;
			if (res.dest_written) begin
				reg_vld_q[x_s1] <= 1'b1;
			end
			if (res.dest_written && (x_s1 == REG_V0)) begin
				v0_q <= res.dest_value;
			end
			if (res.dest_written && (x_s1 == REG_VF)) begin
				vf_q <= res.dest_value;
			end else if (res.flag_written) begin
				vf_q <= {{(REG_W-1){1'b0}}, res.flag_value};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			next_pc        <= res.next_pc;
			index_value    <= res.index_value;
			dest_reg       <= res.dest_reg;
			dest_value     <= res.dest_value;
			dest_written   <= res.dest_written;
			flag_value     <= res.flag_value;
			flag_written   <= res.flag_written;
			skipped        <= res.skipped;
			unknown_opcode <= res.unknown_opcode;
		end
	end

endmodule

// File: test/c8ie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_checker
// Watches both channels of the instruction execute core. Every accepted
// instruction is run through a local copy of the register file, pc and
// index register. The expected result is queued and then compared, field by
// field, with each accepted result transaction.
// ----------------------------------------------------------------------------
module c8ie_checker
	import c8ie_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [15:0]       instruction_word,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [ADDR_W-1:0] next_pc,
	input  logic [ADDR_W-1:0] index_value,
	input  logic [RIDX_W-1:0] dest_reg,
	input  logic [REG_W-1:0]  dest_value,
	input  logic              dest_written,
	input  logic              flag_value,
	input  logic              flag_written,
	input  logic              skipped,
	input  logic              unknown_opcode,
	output int                fail_count,
	output int                pending,
	output int                results_seen,
	output int                skips_seen,
	output int                flags_seen,
	output int                unknown_seen
);

	logic [REG_W-1:0]  vreg [16];
	logic [ADDR_W-1:0] pc_q;
	logic [ADDR_W-1:0] index_q;
	exec_t             predicted_execs [$];

	// Executes one word on the local state and returns what the core should report.
	function automatic exec_t execute_word(input logic [15:0] w);
		logic [3:0]        op;
		logic [3:0]        x;
		logic [3:0]        y;
		logic [3:0]        sub;
		logic [7:0]        nn;
		logic [11:0]       nnn;
		logic [7:0]        vx;
		logic [7:0]        vy;
		logic [7:0]        dv;
		logic              fv;
		logic              dw;
		logic              fw;
		logic              skip;
		logic              unk;
		logic [ADDR_W-1:0] pc_n;
		exec_t             r;
		op   = w[15:12];
		x    = w[11:8];
		y    = w[7:4];
		sub  = w[3:0];
		nn   = w[7:0];
		nnn  = w[11:0];
		vx   = vreg[x];
		vy   = vreg[y];
		dv   = '0;
		fv   = 1'b0;
		dw   = 1'b0;
		fw   = 1'b0;
		skip = 1'b0;
		unk  = 1'b0;
		pc_n = pc_q;
		case (op)
			OP_JP:      pc_n = nnn;
			OP_SE_IMM:  skip = (vx == nn);
			OP_SNE_IMM: skip = (vx != nn);
			OP_SE_REG:  skip = (vx == vy);
			OP_SNE_REG: skip = (vx != vy);
			OP_LD_IMM: begin
				dw = 1'b1;
				dv = nn;
			end
			OP_ADD_IMM: begin
				dw = 1'b1;
				dv = vx + nn;
			end
			OP_ALU: begin
				case (sub)
					ALU_MOV: begin dw = 1'b1; dv = vy; end
					ALU_OR:  begin dw = 1'b1; dv = vx | vy; end
					ALU_AND: begin dw = 1'b1; dv = vx & vy; end
					ALU_XOR: begin dw = 1'b1; dv = vx ^ vy; end
					ALU_ADD: begin
						dw = 1'b1;
						fw = 1'b1;
						{fv, dv} = {1'b0, vx} + {1'b0, vy};
					end
					ALU_SUB: begin
						dw = 1'b1;
						fw = 1'b1;
						dv = vx - vy;
						fv = (vx >= vy);
					end
					ALU_SHR: begin
						dw = 1'b1;
						fw = 1'b1;
						dv = vx >> 1;
						fv = vx[0];
					end
					ALU_RSB: begin
						dw = 1'b1;
						fw = 1'b1;
						dv = vy - vx;
						fv = (vy >= vx);
					end
					ALU_SHL: begin
						dw = 1'b1;
						fw = 1'b1;
						dv = {vx[6:0], 1'b0};
						fv = vx[7];
					end
					default: ; // unknown sub-op: pc advance only
				endcase
			end
			OP_LD_I:   index_q = nnn;
			OP_JP_V0:  pc_n = {4'h0, vreg[REG_V0]} + nnn;
			default:   unk = 1'b1;
		endcase
		if (!unk && op != OP_JP && op != OP_JP_V0)
			pc_n = pc_q + (skip ? 12'd4 : 12'd2);
		// flag lands first so that a write to VF by the result wins
		if (fw)
			vreg[REG_VF] = {7'b0, fv};
		if (dw)
			vreg[x] = dv;
		pc_q = pc_n;
		r.next_pc        = pc_q;
		r.index_value    = index_q;
		r.dest_reg       = dw ? x : '0;
		r.dest_value     = dw ? dv : '0;
		r.dest_written   = dw;
		r.flag_value     = fw ? fv : 1'b0;
		r.flag_written   = fw;
		r.skipped        = skip;
		r.unknown_opcode = unk;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [11:0] exp_v,
			input logic [11:0] act_v);
		if (act_v !== exp_v) begin
			fail_count++;
			$display("%0t: result %0d %s mismatch, expected 0x%0h, got 0x%0h",
				$time, results_seen, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		exec_t e;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				vreg[i] = '0;
			pc_q    = PC_RESET;
			index_q = '0;
			predicted_execs.delete();
			fail_count   = 0;
			pending      = 0;
			results_seen = 0;
			skips_seen   = 0;
			flags_seen   = 0;
			unknown_seen = 0;
		end else begin
			// result side first: a word taken at this edge cannot be out yet
			if (out_valid && !out_stall) begin
				if (predicted_execs.size() == 0) begin
					fail_count++;
					$display("%0t: result transaction with nothing expected, pc 0x%0h",
						$time, next_pc);
				end else begin
					e = predicted_execs.pop_front();
					check_field("next_pc",        e.next_pc,        next_pc);
					check_field("index_value",    e.index_value,    index_value);
					check_field("dest_reg",       12'(e.dest_reg),  12'(dest_reg));
					check_field("dest_value",     12'(e.dest_value), 12'(dest_value));
					check_field("dest_written",   12'(e.dest_written), 12'(dest_written));
					check_field("flag_value",     12'(e.flag_value), 12'(flag_value));
					check_field("flag_written",   12'(e.flag_written), 12'(flag_written));
					check_field("skipped",        12'(e.skipped),   12'(skipped));
					check_field("unknown_opcode", 12'(e.unknown_opcode),
						12'(unknown_opcode));
					skips_seen   += int'(e.skipped);
					flags_seen   += int'(e.flag_written);
					unknown_seen += int'(e.unknown_opcode);
				end
				results_seen++;
			end
			if (in_valid && !in_stall)
				predicted_execs.push_back(execute_word(instruction_word));
			pending = predicted_execs.size();
		end
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives instruction words into the execute core: a directed set covering
// every supported opcode, every sub-op but MOV and corner cases, then random
// words over four idle/stall phases. The checker beside the core does all the comparing.
// ----------------------------------------------------------------------------
module tb_top;
	import c8ie_pkg::*;

	localparam int RANDOM_PER_PHASE = 100;
	localparam int NUM_PHASES       = 4;
	localparam int DRAIN_CYCLES     = 8;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int NUM_DIRECTED     = 30;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [15:0]       instruction_word;
	logic              out_valid;
	logic              out_stall;
	logic [ADDR_W-1:0] next_pc;
	logic [ADDR_W-1:0] index_value;
	logic [RIDX_W-1:0] dest_reg;
	logic [REG_W-1:0]  dest_value;
	logic              dest_written;
	logic              flag_value;
	logic              flag_written;
	logic              skipped;
	logic              unknown_opcode;

	int fail_count;
	int pending;
	int results_seen;
	int skips_seen;
	int flags_seen;
	int unknown_seen;
	int idle_pct;
	int stall_pct;
	int words_sent;
	int cycle_count;

	// Idle and stall rates (percent of cycles) per random phase: clean
	// streaming, starved input, back-pressured output, then both.
	int phase_idle  [NUM_PHASES] = '{0, 81, 0, 30};
	int phase_stall [NUM_PHASES] = '{0, 0, 81, 30};

	// Directed words, run in order from the reset state (V0..VF = 0, pc 0x200).
	logic [15:0] directed_words [NUM_DIRECTED] = '{
		16'h0000,  // unsupported top-level 0, all bits low
		16'h60FF,  // V0 = FF
		16'h6E01,  // VE = 01
		16'h8E04,  // VE + V0 carries out: VE = 00, flag 1
		16'h7FFF,  // VF (holding the flag) + FF wraps to 00
		16'h3000,  // V0 != 00: no skip
		16'h30FF,  // V0 == FF: skip
		16'h4000,  // V0 != 00: skip
		16'h5E0F,  // VE vs V0 with a nonzero low nibble, treated as 5XY0
		16'h90EF,  // V0 != VE: skip, low nibble ignored
		16'h6F80,  // VF = 80
		16'h8FF4,  // VF + VF carries; result then overwrites the flag in VF
		16'h6281,  // V2 = 81
		16'h8021,  // OR
		16'h8022,  // AND
		16'h8023,  // XOR
		16'h8025,  // SUB, flag = no borrow
		16'h8027,  // reverse SUB
		16'h8026,  // shift right, flag = old bit 0
		16'h802E,  // shift left, flag = old bit 7
		16'h8028,  // unknown sub-op: pc advance only
		16'h802F,  // unknown sub-op, top value
		16'hAFFF,  // index = FFF
		16'h60FF,  // V0 = FF for the jump below
		16'hBFFF,  // V0 + FFF wraps to 0FE
		16'h1FFE,  // jump to the last word of the address space
		16'h30FF,  // skip from FFE wraps pc to 002
		16'hC0FF,  // unsupported top-level C
		16'hEFFF,  // unsupported top-level E
		16'hFFFF   // unsupported top-level F, all bits high
	};

	chip8_instruction_execute_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.instruction_word(instruction_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.next_pc        (next_pc),
		.index_value    (index_value),
		.dest_reg       (dest_reg),
		.dest_value     (dest_value),
		.dest_written   (dest_written),
		.flag_value     (flag_value),
		.flag_written   (flag_written),
		.skipped        (skipped),
		.unknown_opcode (unknown_opcode)
	);

	c8ie_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.instruction_word(instruction_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.next_pc        (next_pc),
		.index_value    (index_value),
		.dest_reg       (dest_reg),
		.dest_value     (dest_value),
		.dest_written   (dest_written),
		.flag_value     (flag_value),
		.flag_written   (flag_written),
		.skipped        (skipped),
		.unknown_opcode (unknown_opcode),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_seen   (results_seen),
		.skips_seen     (skips_seen),
		.flags_seen     (flags_seen),
		.unknown_seen   (unknown_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver back-pressure, redrawn every falling edge.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: a hung handshake or a lost result ends up here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results still expected",
			cycle_count, pending);
		$display("Simulation FAILED");
		$finish;
	end

	// Byte values that sit on carry, borrow and sign boundaries.
	function automatic logic [7:0] edge_byte();
		case ($urandom_range(5))
			0:       return 8'h00;
			1:       return 8'h01;
			2:       return 8'h7F;
			3:       return 8'h80;
			4:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly well-formed instructions with random operands; some raw noise
	// so unsupported opcodes and unknown sub-ops keep turning up.
	function automatic logic [15:0] rand_word();
		logic [3:0]  ops [12] = '{OP_JP, OP_SE_IMM, OP_SNE_IMM, OP_SE_REG, OP_LD_IMM,
			OP_ADD_IMM, OP_ALU, OP_ALU, OP_ALU, OP_SNE_REG, OP_LD_I, OP_JP_V0};
		logic [3:0]  subs [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
			ALU_SUB, ALU_SHR, ALU_RSB, ALU_SHL};
		logic [15:0] w;
		int          pick;
		pick = $urandom_range(99);
		w    = 16'($urandom);
		if (pick < 8)
			return w;
		if (pick < 22)
			return {OP_LD_IMM, w[11:8], edge_byte()};
		w[15:12] = ops[$urandom_range(11)];
		case (w[15:12])
			OP_SE_IMM, OP_SNE_IMM, OP_ADD_IMM: w[7:0] = edge_byte();
			OP_SE_REG, OP_SNE_REG: begin
				if ($urandom_range(2) == 0)
					w[7:4] = w[11:8];  // same register: compare always equal
			end
			OP_ALU: begin
				if ($urandom_range(9) != 0)
					w[3:0] = subs[$urandom_range(8)];
			end
			default: ;
		endcase
		return w;
	endfunction

	// One input transaction: optional idle cycles, then hold until accepted.
	task automatic send_word(input logic [15:0] w);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid         = 1'b1;
		instruction_word = w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	initial begin
		in_valid         = 1'b0;
		instruction_word = '0;
		arst_n           = 1'b0;
		idle_pct         = 0;
		stall_pct        = 0;
		words_sent       = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part runs with no idling so the state sequence is exact
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_word(directed_words[i]);

		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_pct  = phase_idle[p];
			stall_pct = phase_stall[p];
			repeat (RANDOM_PER_PHASE)
				send_word(rand_word());
		end
		in_valid = 1'b0;

		// let every expected result drain, then a few quiet cycles
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Executed %0d instruction words (%0d directed) over %0d idle/stall phases.",
			words_sent, NUM_DIRECTED, NUM_PHASES);
		$display("Checked %0d results: %0d skips, %0d flag writes, %0d unsupported, %0d errors.",
			results_seen, skips_seen, flags_seen, unknown_seen, fail_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
